// File: hw/rtl/vdb_pkg.sv
package vdb_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = IDX_W + 1;
	localparam int COMP_N      = 8;
	localparam int COMP_W      = 32;
	localparam int ENTRY_W     = COMP_N * COMP_W;
	localparam int TOL_W       = 16;
	localparam int VIDX_W      = 10;
	localparam int BOX_N       = 3;

	localparam logic [TOL_W-1:0]  TOL_RESET     = 16'd7;
	localparam logic [COMP_W-1:0] BOX_MOST_POS  = 32'h7FFF_FFFF;
	localparam logic [COMP_W-1:0] BOX_MOST_NEG  = 32'h8000_0000;

	// component order: pos x/y/z, tex u/v, normal x/y/z
	typedef logic [COMP_N-1:0][COMP_W-1:0] corner_t;
	typedef logic [BOX_N-1:0][COMP_W-1:0]  box_vec_t;

	typedef struct packed {
		logic clear;
		logic widen;
	} box_ctl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_COMMIT,
		ST_EMIT
	} seq_state_t;

endpackage

// File: hw/rtl/vertex_dedup_with_bounds.sv
// Vertex welding with a running bounding box of stored positions.
// Input channel (s_*): one beat is one triangle corner, eight signed Q16.16
// components in s_tdata; s_tuser[0] is mesh_start, which empties the vertex
// table and resets the box before the corner is handled.
// Output channel (m_*): one beat per corner with the vertex index, the
// is_new / table_full flags in m_tuser and the box after that corner.
// cfg_we / cfg_wdata write match_tolerance (reset 7); the user must do so only
// while the block is idle, and the block itself does not enforce it. Each
// accepted corner passes the sequencer states scan, commit and emit in order.
// The scan reads the vertex table one entry per cycle through its single
// read port and stops at the first match. s_tready is high only while the
// sequencer is idle; it rises with m_tvalid.
// The result sits in an output register: while it waits for m_tready the
// next corner is accepted and scanned, but that corner's result then holds
// in the sequencer and s_tready stays low until the register is handed off.
// Reset: table empty, box at most positive min / most negative max,
// tolerance back to 7, no output beat pending. No clearing pass is needed.
module vertex_dedup_with_bounds (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [15:0]   cfg_wdata,       // match_tolerance
	input  logic          s_tvalid,
	output logic          s_tready,
	// pos_x, pos_y, pos_z, tex_u, tex_v, norm_x, norm_y, norm_z (32 bits each)
	input  logic [255:0]  s_tdata,
	input  logic [0:0]    s_tuser,         // mesh_start
	output logic          m_tvalid,
	input  logic          m_tready,
	// vertex_index[9:0], box_min_x, box_min_y, box_min_z,
	// box_max_x, box_max_y, box_max_z (32 bits each), 6 zero pad bits
	output logic [207:0]  m_tdata,
	output logic [1:0]    m_tuser          // is_new, table_full
);
	import vdb_pkg::*;

	seq_state_t state_q, state_nxt;

	logic [TOL_W-1:0]  tol_q;
	corner_t           corner_q;
	logic [CNT_W-1:0]  total_q;
	logic [CNT_W-1:0]  iss_q;
	logic              rd_vld_s1;
	logic [IDX_W-1:0]  rd_idx_s1;
	logic              found_q;
	logic [IDX_W-1:0]  found_idx_q;
	logic [IDX_W-1:0]  res_idx_q;
	logic              res_new_q;
	logic              res_full_q;

	logic              m_tvalid_q;
	logic [VIDX_W-1:0] m_idx_q;
	logic              m_new_q;
	logic              m_full_q;
	box_vec_t          m_min_q;
	box_vec_t          m_max_q;

	logic              accept;
	logic              issue;
	logic              scan_hit;
	logic              scan_miss;
	logic              room;
	logic              commit_wr;
	logic              emit_load;
	logic              hit;
	corner_t           rd_entry;
	box_ctl_t          box_ctl;
	box_vec_t          pos_vec;
	box_vec_t          box_min;
	box_vec_t          box_max;

	// ---------------- sequencer control ----------------
	always_comb begin
		s_tready  = (state_q == ST_IDLE);
		accept    = s_tvalid && (state_q == ST_IDLE);
		// issue the next table read while entries remain
		issue     = (state_q == ST_SCAN) && (iss_q < total_q);
		// registered read data compared this cycle
		scan_hit  = (state_q == ST_SCAN) && rd_vld_s1 && hit;
		// nothing in flight and nothing left to read: a miss
		scan_miss = (state_q == ST_SCAN) && !rd_vld_s1 && (iss_q == total_q);
		room      = total_q < CNT_W'(TABLE_DEPTH);
		commit_wr = (state_q == ST_COMMIT) && !found_q && room;
		emit_load = (state_q == ST_EMIT) && (!m_tvalid_q || m_tready);
		box_ctl.clear = accept && s_tuser[0];
		box_ctl.widen = commit_wr;
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) state_nxt = ST_SCAN;
			end
			ST_SCAN: begin
				if (scan_hit || scan_miss) state_nxt = ST_COMMIT;
			end
			ST_COMMIT: begin
				state_nxt = ST_EMIT;
			end
			ST_EMIT: begin
				if (emit_load) state_nxt = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// ---------------- configuration ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TOL_RESET;
		end else if (cfg_we) begin
			tol_q <= cfg_wdata;
		end
	end

	// ---------------- corner capture ----------------
	always_ff @(posedge clk) begin
		if (accept) begin
			corner_q <= corner_t'(s_tdata);
		end
	end

	// ---------------- scan pointer and table fill ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q   <= '0;
			iss_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (accept) begin
				iss_q     <= '0;
				rd_vld_s1 <= 1'b0;
				// drop the whole table at mesh start
				if (s_tuser[0]) total_q <= '0;
			end else if (state_q == ST_SCAN) begin
				rd_vld_s1 <= issue;
				if (issue) iss_q <= iss_q + CNT_W'(1);
			end
			if (commit_wr) total_q <= total_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SCAN) rd_idx_s1 <= iss_q[IDX_W-1:0];
		if (scan_hit) begin
			found_q     <= 1'b1;
			found_idx_q <= rd_idx_s1;
		end else if (scan_miss) begin
			found_q <= 1'b0;
		end
	end

	// ---------------- result of one corner ----------------
	always_ff @(posedge clk) begin
		if (state_q == ST_COMMIT) begin
			if (found_q) begin
				res_idx_q  <= found_idx_q;
				res_new_q  <= 1'b0;
				res_full_q <= 1'b0;
			end else if (room) begin
				res_idx_q  <= total_q[IDX_W-1:0];
				res_new_q  <= 1'b1;
				res_full_q <= 1'b0;
			end else begin
				res_idx_q  <= '0;
				res_new_q  <= 1'b0;
				res_full_q <= 1'b1;
			end
		end
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (emit_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			m_idx_q  <= VIDX_W'(res_idx_q);
			m_new_q  <= res_new_q;
			m_full_q <= res_full_q;
			m_min_q  <= box_min;
			m_max_q  <= box_max;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {6'd0, m_max_q[2], m_max_q[1], m_max_q[0],
	                   m_min_q[2], m_min_q[1], m_min_q[0], m_idx_q};
	assign m_tuser  = {m_full_q, m_new_q};

	// ---------------- datapath units ----------------
	vdb_table u_table (
		.clk   (clk),
		.we    (commit_wr),
		.waddr (total_q[IDX_W-1:0]),
		.wdata (corner_q),
		.re    (issue),
		.raddr (iss_q[IDX_W-1:0]),
		.rdata (rd_entry)
	);

	vdb_match u_match (
		.corner (corner_q),
		.entry  (rd_entry),
		.tol    (tol_q),
		.hit    (hit)
	);

	assign pos_vec = {corner_q[2], corner_q[1], corner_q[0]};

	vdb_box u_box (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (box_ctl),
		.pos     (pos_vec),
		.box_min (box_min),
		.box_max (box_max)
	);

endmodule

// File: hw/rtl/vdb_table.sv
module vdb_table (
	input  logic                           clk,
	input  logic                           we,
	input  logic [vdb_pkg::IDX_W-1:0]      waddr,
	input  vdb_pkg::corner_t               wdata,
	input  logic                           re,
	input  logic [vdb_pkg::IDX_W-1:0]      raddr,
	output vdb_pkg::corner_t               rdata
);
	import vdb_pkg::*;

	logic [ENTRY_W-1:0] mem [TABLE_DEPTH];
	logic [ENTRY_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = corner_t'(rdata_q);

endmodule

// File: hw/rtl/vdb_match.sv
module vdb_match (
	input  vdb_pkg::corner_t               corner,
	input  vdb_pkg::corner_t               entry,
	input  logic [vdb_pkg::TOL_W-1:0]      tol,
	output logic                           hit
);
	import vdb_pkg::*;

	logic [COMP_N-1:0] close;

	// 33-bit difference cannot overflow; magnitude fits 33 bits unsigned
	always_comb begin
		logic signed [COMP_W:0] diff;
		logic [COMP_W:0]        mag;
		for (int k = 0; k < COMP_N; k++) begin
			diff = $signed({corner[k][COMP_W-1], corner[k]})
			     - $signed({entry[k][COMP_W-1], entry[k]});
			mag  = diff[COMP_W] ? (COMP_W+1)'(-diff) : (COMP_W+1)'(diff);
			close[k] = mag < (COMP_W+1)'(tol);
		end
	end

	assign hit = &close;

endmodule

// File: hw/rtl/vdb_box.sv
module vdb_box (
	input  logic                 clk,
	input  logic                 arst_n,
	input  vdb_pkg::box_ctl_t    ctl,
	input  vdb_pkg::box_vec_t    pos,
	output vdb_pkg::box_vec_t    box_min,
	output vdb_pkg::box_vec_t    box_max
);
	import vdb_pkg::*;

	box_vec_t min_q;
	box_vec_t max_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < BOX_N; k++) begin
				min_q[k] <= BOX_MOST_POS;
				max_q[k] <= BOX_MOST_NEG;
			end
		end else if (ctl.clear) begin
			for (int k = 0; k < BOX_N; k++) begin
				min_q[k] <= BOX_MOST_POS;
				max_q[k] <= BOX_MOST_NEG;
			end
		end else if (ctl.widen) begin
			for (int k = 0; k < BOX_N; k++) begin
				if ($signed(pos[k]) < $signed(min_q[k])) begin
					min_q[k] <= pos[k];
				end
				if ($signed(pos[k]) > $signed(max_q[k])) begin
					max_q[k] <= pos[k];
				end
			end
		end
	end

	assign box_min = min_q;
	assign box_max = max_q;

endmodule

// File: test/vertex_dedup_with_bounds_tb.sv
module vertex_dedup_with_bounds_tb;
	import vdb_pkg::*;

	// Pacing of the two sides of the stream.
	localparam int unsigned GAP_MAX     = 8;
	localparam int unsigned STALL_MAX   = 32;
	localparam int unsigned HOLDOFF_LEN = 400;
	// Upper bound on corners sent in one run: directed, table fill, random meshes.
	localparam int unsigned MAX_ITEMS   = 1800;
	// Every corner scanning the whole table, with the worst gap and stall on top.
	localparam int unsigned CYCLE_LIMIT =
		4 * (MAX_ITEMS * (TABLE_DEPTH + 5 + GAP_MAX + STALL_MAX) + HOLDOFF_LEN);

	typedef struct {
		bit      mesh_start;
		corner_t comps;
	} corner_beat_t;

	typedef struct {
		logic [VIDX_W-1:0] index;
		logic              is_new;
		logic              full;
		box_vec_t          lo;
		box_vec_t          hi;
	} weld_result_t;

	typedef enum {
		RX_OPEN,
		RX_CHOPPY,
		RX_SPARSE
	} rx_mode_t;

	logic         clk = 1'b0;
	logic         arst_n;
	logic         cfg_we = 1'b0;
	logic [15:0]  cfg_wdata = '0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [255:0] s_tdata = '0;
	logic [0:0]   s_tuser = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [207:0] m_tdata;
	logic [1:0]   m_tuser;

	vertex_dedup_with_bounds uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	always #1 clk = ~clk;

	// Corners waiting to go out; the head is the beat currently offered.
	corner_beat_t corners_pending[$];
	// Predicted output beats, oldest first.
	weld_result_t welds_due[$];

	int unsigned cycle_count = 0;
	int unsigned err_count = 0;
	bit          corner_accepted = 1'b0;

	// Sender pacing
	int unsigned burst_left = 1;
	int unsigned gap_left = 0;

	// Receiver pacing; the stimulus bumps holdoff_reqs to ask for a long stall.
	int unsigned holdoff_reqs = 0;
	int unsigned holdoff_served = 0;
	int unsigned holdoff_left = 0;
	int unsigned rx_span = 0;
	rx_mode_t    rx_mode = RX_OPEN;

	// Shadow copy of the vertex table, the box and the tolerance.
	corner_t     vtab [TABLE_DEPTH];
	int unsigned vtotal = 0;
	box_vec_t    box_lo = {BOX_N{BOX_MOST_POS}};
	box_vec_t    box_hi = {BOX_N{BOX_MOST_NEG}};
	logic [15:0] weld_tol = TOL_RESET;

	task automatic flag_mismatch(string msg);
		err_count++;
		$display("mismatch at cycle %0d: %s", cycle_count, msg);
	endtask

	// Difference taken at 64 bits so extremes never wrap into a match.
	function automatic bit comp_near(logic [31:0] a, logic [31:0] b);
		longint d;
		d = longint'($signed(a)) - longint'($signed(b));
		if (d < 0)
			d = -d;
		return d < longint'(weld_tol);
	endfunction

	// Weld one corner into the shadow table and return the beat it should produce.
	function automatic weld_result_t weld_corner(bit mstart, corner_t c);
		weld_result_t r;
		bit           hit;
		bit           all_near;
		int unsigned  i;
		int unsigned  slot;
		int           k;
		hit = 1'b0;
		slot = 0;
		r.is_new = 1'b0;
		r.full = 1'b0;
		if (mstart) begin
			vtotal = 0;
			box_lo = {BOX_N{BOX_MOST_POS}};
			box_hi = {BOX_N{BOX_MOST_NEG}};
		end
		// Lowest matching entry wins.
		for (i = 0; i < vtotal && !hit; i++) begin
			all_near = 1'b1;
			for (k = 0; k < COMP_N; k++)
				if (!comp_near(c[k], vtab[i][k]))
					all_near = 1'b0;
			if (all_near) begin
				hit = 1'b1;
				slot = i;
			end
		end
		if (!hit) begin
			if (vtotal < TABLE_DEPTH) begin
				slot = vtotal;
				vtab[slot] = c;
				vtotal++;
				for (k = 0; k < BOX_N; k++) begin
					if ($signed(c[k]) < $signed(box_lo[k]))
						box_lo[k] = c[k];
					if ($signed(c[k]) > $signed(box_hi[k]))
						box_hi[k] = c[k];
				end
				r.is_new = 1'b1;
			end else begin
				// Table full: nothing stored, index reads as zero.
				r.full = 1'b1;
				slot = 0;
			end
		end
		r.index = VIDX_W'(slot);
		r.lo = box_lo;
		r.hi = box_hi;
		return r;
	endfunction

	// Sender: present the head of the queue, hold it until taken, pause between bursts.
	always @(negedge clk) begin : tx
		bit offer;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || corner_accepted) begin
			if (s_tvalid)
				void'(corners_pending.pop_front());
			offer = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
			end else if (corners_pending.size() > 0) begin
				offer = 1'b1;
				s_tdata <= corners_pending[0].comps;
				s_tuser <= corners_pending[0].mesh_start;
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 12);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, GAP_MAX);
				end else begin
					burst_left--;
				end
			end
			s_tvalid <= offer;
		end
	end

	// Receiver: a long hold-off on request, otherwise stretches of open, choppy
	// or sparse readiness.
	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (holdoff_served != holdoff_reqs) begin
			holdoff_served <= holdoff_reqs;
			holdoff_left <= HOLDOFF_LEN;
			m_tready <= 1'b0;
		end else if (holdoff_left > 0) begin
			holdoff_left <= holdoff_left - 1;
			m_tready <= 1'b0;
		end else begin
			if (rx_span == 0) begin
				rx_mode <= rx_mode_t'($urandom_range(0, 2));
				rx_span <= $urandom_range(8, 60);
			end else begin
				rx_span <= rx_span - 1;
			end
			case (rx_mode)
				RX_OPEN:   m_tready <= 1'b1;
				RX_CHOPPY: m_tready <= $urandom_range(0, 1);
				default:   m_tready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// Monitor: predict on every accepted corner, check every delivered beat.
	always @(posedge clk) begin : mon
		weld_result_t want;
		logic [31:0]  got_w;
		int           k;
		corner_accepted <= s_tvalid && s_tready;
		if (s_tvalid && s_tready)
			welds_due.push_back(weld_corner(s_tuser[0], s_tdata));
		if (m_tvalid && m_tready) begin
			if (welds_due.size() == 0) begin
				flag_mismatch("output beat with no corner outstanding");
			end else begin
				want = welds_due.pop_front();
				if (m_tdata[VIDX_W-1:0] !== want.index)
					flag_mismatch($sformatf("vertex_index got %0d want %0d",
						m_tdata[VIDX_W-1:0], want.index));
				if (m_tuser[0] !== want.is_new)
					flag_mismatch($sformatf("is_new got %b want %b", m_tuser[0], want.is_new));
				if (m_tuser[1] !== want.full)
					flag_mismatch($sformatf("table_full got %b want %b", m_tuser[1], want.full));
				for (k = 0; k < BOX_N; k++) begin
					got_w = m_tdata[VIDX_W + COMP_W*k +: COMP_W];
					if (got_w !== want.lo[k])
						flag_mismatch($sformatf("box_min[%0d] got %h want %h", k, got_w, want.lo[k]));
					got_w = m_tdata[VIDX_W + COMP_W*(BOX_N + k) +: COMP_W];
					if (got_w !== want.hi[k])
						flag_mismatch($sformatf("box_max[%0d] got %h want %h", k, got_w, want.hi[k]));
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("vertex_dedup_with_bounds verification failed");
			$finish;
		end
	end

	task automatic offer_corner(bit mstart, corner_t c);
		corner_beat_t b;
		b.mesh_start = mstart;
		b.comps = c;
		corners_pending.push_back(b);
	endtask

	// Hold until every corner is out and every result is back, then settle.
	task automatic drain(int unsigned settle);
		do
			@(negedge clk);
		while (corners_pending.size() != 0 || welds_due.size() != 0);
		repeat (settle) @(negedge clk);
	endtask

	// Write the tolerance while the block is idle.
	task automatic load_tolerance(logic [15:0] t);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_wdata = t;
		weld_tol = t;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// Lean on the Q16.16 extremes and tiny values so collisions happen.
	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 9))
			0:       return BOX_MOST_POS;
			1:       return BOX_MOST_NEG;
			2:       return 32'h0;
			3:       return 32'hFFFF_FFFF;
			4:       return 32'($urandom_range(0, 255)) - 32'd128;
			default: return $urandom;
		endcase
	endfunction

	function automatic corner_t rand_corner();
		corner_t c;
		for (int k = 0; k < COMP_N; k++)
			c[k] = rand_word();
		return c;
	endfunction

	// Move every component by a random amount in [-span, span].
	function automatic corner_t jitter(corner_t c, int unsigned span);
		for (int k = 0; k < COMP_N; k++)
			c[k] = c[k] + 32'($urandom_range(0, 2*span)) - 32'(span);
		return c;
	endfunction

	// Meshes built from a small pool of vertices, revisited inside the tolerance,
	// right on its edge, exactly, or jittered by up to twice the tolerance plus 5.
	task automatic random_meshes(int unsigned n_items);
		corner_t     pool[$];
		corner_t     c;
		int unsigned sent;
		int unsigned mesh_left;
		int unsigned r;
		int unsigned k;
		bit          mstart;
		sent = 0;
		mesh_left = 0;
		while (sent < n_items) begin
			mstart = 1'b0;
			if (mesh_left == 0) begin
				mstart = 1'b1;
				mesh_left = $urandom_range(4, 40);
				pool.delete();
			end
			r = $urandom_range(0, 99);
			if (pool.size() == 0 || r < 25) begin
				c = rand_corner();
				pool.push_back(c);
			end else begin
				c = pool[$urandom_range(0, pool.size() - 1)];
				if (r < 60) begin
					c = jitter(c, (weld_tol == 0) ? 0 : weld_tol - 1);
				end else if (r < 75) begin
					k = $urandom_range(0, COMP_N - 1);
					c[k] = $urandom_range(0, 1) ? c[k] + weld_tol : c[k] - weld_tol;
				end else if (r >= 90) begin
					c = jitter(c, 2 * weld_tol + 5);
				end
			end
			// Stray restart in the middle of a mesh.
			if ($urandom_range(0, 49) == 0)
				mstart = 1'b1;
			offer_corner(mstart, c);
			sent++;
			mesh_left--;
		end
	endtask

	initial begin
		corner_t     hi_c;
		corner_t     lo_c;
		corner_t     b;
		corner_t     m;
		corner_t     probe;
		logic [15:0] tols [6];
		int          k;

		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed, at the reset tolerance.
		hi_c = {COMP_N{BOX_MOST_POS}};
		lo_c = {COMP_N{BOX_MOST_NEG}};
		offer_corner(1'b1, hi_c);
		offer_corner(1'b0, lo_c);               // far apart: no wrap into a match
		offer_corner(1'b0, hi_c);               // exact hit
		for (k = 0; k < COMP_N; k++)
			b[k] = hi_c[k] - 32'd6;
		offer_corner(1'b0, b);                  // just inside the tolerance
		b[3] = hi_c[3] - 32'd7;
		offer_corner(1'b0, b);                  // one component on the bound: miss
		offer_corner(1'b0, '0);
		offer_corner(1'b0, '1);                 // -1 against 0
		m = {COMP_N{32'h0001_0000}};
		offer_corner(1'b0, m);
		offer_corner(1'b0, jitter(m, 0) + {COMP_N{32'd10}});
		for (k = 0; k < COMP_N; k++)
			b[k] = m[k] + 32'd5;
		offer_corner(1'b0, b);                  // matches two entries: lowest wins
		for (k = 0; k < COMP_N; k++)
			b[k] = m[k] + 32'd10;
		offer_corner(1'b1, b);                  // restart: table and box cleared
		offer_corner(1'b0, lo_c);
		drain(8);

		// Zero tolerance: repeats are appended too.
		load_tolerance(16'h0000);
		offer_corner(1'b0, b);
		offer_corner(1'b0, b);
		drain(8);

		// Fill the whole table, then overflow it.
		probe = '0;
		for (k = 0; k < TABLE_DEPTH + 3; k++) begin
			b = rand_corner();
			if (k == 500)
				probe = b;
			offer_corner(k == 0, b);
		end
		drain(8);
		load_tolerance(16'hFFFF);
		offer_corner(1'b0, jitter(probe, 30000));  // hit on a full table
		offer_corner(1'b0, rand_corner());
		offer_corner(1'b0, {COMP_N{32'h4000_0000}});
		drain(8);

		tols[0] = TOL_RESET;
		tols[1] = 16'd1;
		tols[2] = 16'hFFFF;
		tols[3] = 16'($urandom_range(2, 300));
		tols[4] = 16'($urandom_range(0, 65535));
		tols[5] = 16'd0;
		for (k = 0; k < 6; k++) begin
			load_tolerance(tols[k]);
			// Stall the receiver while corners keep coming.
			if (k == 0 || k == 3)
				holdoff_reqs++;
			random_meshes(97);
			drain(8);
		end

		drain(TABLE_DEPTH + 8);
		if (err_count == 0)
			$display("vertex_dedup_with_bounds verification clean");
		else
			$display("vertex_dedup_with_bounds verification failed");
		$finish;
	end

endmodule
